[design/sv32ptw_pkg.sv]
// Shared types and codes for the Sv32 page table walker.
// Holds result kinds, fault codes, register indexes and the result record.
// No dependencies.
package sv32ptw_pkg;

  localparam int unsigned OutDepth = 4;
  localparam int unsigned PtrW     = $clog2(OutDepth);
  localparam int unsigned CntW     = $clog2(OutDepth + 1);
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [1:0] {
    RkRead  = 2'd0,
    RkWrite = 2'd1,
    RkDone  = 2'd2
  } res_kind_e;

  typedef enum logic [1:0] {
    FsOk     = 2'd0,
    FsAccess = 2'd1,
    FsPage   = 2'd2
  } fault_e;

  localparam logic [1:0] AccFetch = 2'd0;
  localparam logic [1:0] AccLoad  = 2'd1;
  localparam logic [1:0] AccStore = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgSatp  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPriv  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSum   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMxr   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLimit = 3'd4;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhL1   = 2'd1;
  localparam logic [1:0] PhL0   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] pte;
    logic [31:0] phys;
    logic [1:0]  status;
    logic [1:0]  acc;
    logic        last;
  } result_t;

endpackage

[design/sv32_page_table_walker_top.sv]
// Sv32 two-level page table walker, top level.
// Depends on sv32ptw_pkg for codes and the result record.
//
//  channel | dir | handshake               | payload
//  in      | in  | in_valid_i / in_ready_o   | item_kind, virt_addr, access_kind, pte_word
//  out     | out | out_valid_o / out_ready_i | result_kind .. last_result
//  cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One input item per cycle while in_ready_o is high: the walk state updates at the
// transfer and the results of the item enter a four-entry result queue in the same cycle.
// Results leave the queue one per cycle while out_ready_i is high; each can be shown from
// the cycle after it is queued. Input is held off while fewer than two queue slots are
// free. Reset empties the queue and returns walk state and registers to their defaults.
module sv32_page_table_walker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        item_kind_i,
  input  logic [31:0] virt_addr_i,
  input  logic [1:0]  access_kind_i,
  input  logic [31:0] pte_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [31:0] mem_address_o,
  output logic [31:0] pte_out_o,
  output logic [31:0] phys_addr_o,
  output logic [1:0]  fault_status_o,
  output logic [1:0]  fault_access_o,
  output logic        last_result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [sv32ptw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import sv32ptw_pkg::*;

  logic [31:0] satp_q, limit_q;
  logic        priv_q, sum_q, mxr_q;

  logic [1:0]  phase_q, phase_d;
  logic [31:0] hvaddr_q, hvaddr_d;
  logic [1:0]  hacc_q, hacc_d;
  logic [31:0] eaddr_q, eaddr_d;

  result_t             queue_q [OutDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q, count_d;

  result_t     res0, res1;
  logic [1:0]  push_n;
  logic        in_fire, out_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (count_q <= CntW'(OutDepth - 2));
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;

  always_comb begin
    logic [31:0] addr, pte, base, phys;
    logic [2:0]  xwr;
    logic        r, ok, fault;
    addr     = '0;
    pte      = pte_word_i;
    base     = '0;
    phys     = '0;
    xwr      = pte_word_i[3:1];
    r        = pte_word_i[1];
    ok       = 1'b0;
    fault    = 1'b0;
    phase_d  = phase_q;
    hvaddr_d = hvaddr_q;
    hacc_d   = hacc_q;
    eaddr_d  = eaddr_q;
    push_n   = 2'd0;
    res0     = '0;
    res1     = '0;
    if (in_fire) begin
      if (!item_kind_i) begin
        hvaddr_d = virt_addr_i;
        hacc_d   = access_kind_i;
        push_n   = 2'd1;
        res0.last = 1'b1;
        if (!satp_q[31]) begin
          phase_d     = PhIdle;
          res0.kind   = RkDone;
          res0.phys   = virt_addr_i;
          res0.status = FsOk;
          res0.acc    = access_kind_i;
        end else begin
          addr = {satp_q[19:0], virt_addr_i[31:22], 2'b00};
          if (addr >= limit_q) begin
            phase_d     = PhIdle;
            res0.kind   = RkDone;
            res0.status = FsAccess;
            res0.acc    = access_kind_i;
          end else begin
            phase_d   = PhL1;
            eaddr_d   = addr;
            res0.kind = RkRead;
            res0.addr = addr;
          end
        end
      end else if (phase_q == PhL1 || phase_q == PhL0) begin
        push_n    = 2'd1;
        res0.last = 1'b1;
        res0.kind = RkDone;
        res0.acc  = hacc_q;
        if (!pte_word_i[0] || xwr == 3'd2 || xwr == 3'd6) begin
          fault = 1'b1;
        end else if (xwr == 3'd0) begin
          if (phase_q == PhL1) begin
            addr = {pte_word_i[29:10], hvaddr_q[21:12], 2'b00};
            if (addr >= limit_q) begin
              res0.status = FsAccess;
              phase_d     = PhIdle;
            end else begin
              phase_d   = PhL0;
              eaddr_d   = addr;
              res0.kind = RkRead;
              res0.addr = addr;
              res0.acc  = AccFetch;
            end
          end else begin
            fault = 1'b1;
          end
        end else begin
          if (phase_q == PhL1) begin
            base = {pte_word_i[29:20], hvaddr_q[21:12], 12'h000};
            if (pte_word_i[19:10] != 10'd0) begin
              fault = 1'b1;
            end
          end else begin
            base = {pte_word_i[29:10], 12'h000};
          end
          if (mxr_q && pte_word_i[3]) begin
            r = 1'b1;
          end
          if (!pte_word_i[4] && !priv_q) begin
            fault = 1'b1;
          end
          if (pte_word_i[4] && priv_q && (hacc_q == AccFetch || !sum_q)) begin
            fault = 1'b1;
          end
          ok = (hacc_q == AccFetch && pte_word_i[3]) || (hacc_q == AccLoad && r) ||
               (hacc_q == AccStore && pte_word_i[2]);
          if (!ok) begin
            fault = 1'b1;
          end
          if (!fault) begin
            phys = base | {20'd0, hvaddr_q[11:0]};
            pte[6] = 1'b1;
            if (hacc_q == AccStore) begin
              pte[7] = 1'b1;
            end
            push_n      = 2'd2;
            phase_d     = PhIdle;
            res0        = '0;
            res0.kind   = RkWrite;
            res0.addr   = eaddr_q;
            res0.pte    = pte;
            res1.kind   = RkDone;
            res1.phys   = phys;
            res1.status = FsOk;
            res1.acc    = hacc_q;
            res1.last   = 1'b1;
          end
        end
        if (fault) begin
          phase_d     = PhIdle;
          res0.status = FsPage;
        end
      end
    end
  end

  assign count_d = count_q + CntW'(push_n) - CntW'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      satp_q   <= '0;
      priv_q   <= 1'b0;
      sum_q    <= 1'b0;
      mxr_q    <= 1'b0;
      limit_q  <= '1;
      phase_q  <= PhIdle;
      hvaddr_q <= '0;
      hacc_q   <= '0;
      eaddr_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgSatp:  satp_q  <= cfg_data_i;
          CfgPriv:  priv_q  <= cfg_data_i[0];
          CfgSum:   sum_q   <= cfg_data_i[0];
          CfgMxr:   mxr_q   <= cfg_data_i[0];
          CfgLimit: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      phase_q  <= phase_d;
      hvaddr_q <= hvaddr_d;
      hacc_q   <= hacc_d;
      eaddr_q  <= eaddr_d;
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  result_t head;
  assign head           = queue_q[rd_ptr_q];
  assign result_kind_o  = head.kind;
  assign mem_address_o  = head.addr;
  assign pte_out_o      = head.pte;
  assign phys_addr_o    = head.phys;
  assign fault_status_o = head.status;
  assign fault_access_o = head.acc;
  assign last_result_o  = head.last;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(OutDepth))
    else $error("result queue overfilled");

  a_idle_resp_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && item_kind_i && phase_q == PhIdle |-> push_n == 2'd0)
    else $error("response while idle produced a result");

  a_done_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n != 2'd0 && res0.kind == RkDone |=> phase_q == PhIdle)
    else $error("walk not idle after finish");

  a_pair_is_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n == 2'd2 |-> res0.kind == RkWrite && res1.kind == RkDone && res1.last)
    else $error("two results not write-back then finish");

  a_bypass_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !item_kind_i && !satp_q[31] |=>
      count_q == $past(count_q) + CntW'(1) - CntW'($past(out_fire)))
    else $error("bypass translation did not queue one result");

endmodule

[bench/sv32_page_table_walker_top_test.sv]
// Self-checking bench for the Sv32 two-level page table walker.
// Predicts every result from its own walk model and scores the output transfers.
// Depends on sv32ptw_pkg and sv32_page_table_walker_top.
module sv32_page_table_walker_top_test;
  import sv32ptw_pkg::*;

  localparam logic       ItemReq    = 1'b0;
  localparam logic       ItemPte    = 1'b1;
  localparam logic [1:0] AccBad     = 2'd3;
  localparam int         CycleLimit = 1000000;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic        item_kind_i    = 1'b0;
  logic [31:0] virt_addr_i    = '0;
  logic [1:0]  access_kind_i  = '0;
  logic [31:0] pte_word_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [1:0]  result_kind_o;
  logic [31:0] mem_address_o;
  logic [31:0] pte_out_o;
  logic [31:0] phys_addr_o;
  logic [1:0]  fault_status_o;
  logic [1:0]  fault_access_o;
  logic        last_result_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i     = '0;

  // walk model state and register copies
  logic [1:0]  walk_ph   = PhIdle;
  logic [31:0] held_va   = '0;
  logic [1:0]  held_acc  = '0;
  logic [31:0] entry_adr = '0;
  logic [31:0] satp_r    = '0;
  logic        priv_r    = 1'b0;
  logic        sum_r     = 1'b0;
  logic        mxr_r     = 1'b0;
  logic [31:0] limit_r   = 32'hffff_ffff;

  result_t walk_results_q[$];
  result_t seen_res;
  result_t want_res;

  int unsigned n_walk_items = 0;
  int unsigned n_results    = 0;
  int unsigned n_cfg        = 0;
  int unsigned n_mismatch   = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  bit          no_idle      = 1'b0;

  logic [2:0] leaf_xwr[5] = '{3'd1, 3'd3, 3'd4, 3'd5, 3'd7};

  sv32_page_table_walker_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .item_kind_i    (item_kind_i),
    .virt_addr_i    (virt_addr_i),
    .access_kind_i  (access_kind_i),
    .pte_word_i     (pte_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .mem_address_o  (mem_address_o),
    .pte_out_o      (pte_out_o),
    .phys_addr_o    (phys_addr_o),
    .fault_status_o (fault_status_o),
    .fault_access_o (fault_access_o),
    .last_result_o  (last_result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("%0t: timed out after %0d cycles, %0d results outstanding", $time,
             CycleLimit, walk_results_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function void push_res(input res_kind_e k, input logic [31:0] adr, input logic [31:0] pte,
                         input logic [31:0] phys, input fault_e st, input logic [1:0] acc,
                         input logic last);
    result_t r;
    r.kind   = k;
    r.addr   = adr;
    r.pte    = pte;
    r.phys   = phys;
    r.status = st;
    r.acc    = acc;
    r.last   = last;
    walk_results_q.push_back(r);
  endfunction

  function void close_walk(input fault_e st, input logic [31:0] phys);
    push_res(RkDone, '0, '0, (st == FsOk) ? phys : '0, st, held_acc, 1'b1);
    walk_ph = PhIdle;
  endfunction

  function void issue_read(input logic [31:0] adr, input logic [1:0] nxt);
    if (adr >= limit_r) begin
      close_walk(FsAccess, '0);
    end else begin
      entry_adr = adr;
      walk_ph   = nxt;
      push_res(RkRead, adr, '0, '0, FsOk, 2'd0, 1'b1);
    end
  endfunction

  function void predict_walk(input logic kind, input logic [31:0] va, input logic [1:0] acc,
                             input logic [31:0] pte_w);
    logic [2:0]  xwr;
    logic [31:0] base;
    logic [31:0] wb;
    logic        u, x, w, r, ok;
    if (kind == ItemReq) begin
      held_va  = va;
      held_acc = acc;
      walk_ph  = PhIdle;
      if (!satp_r[31]) close_walk(FsOk, va);
      else issue_read((satp_r << 12) + {20'b0, va[31:22], 2'b00}, PhL1);
      return;
    end
    if (walk_ph != PhL1 && walk_ph != PhL0) return;
    xwr  = pte_w[3:1];
    base = {pte_w[29:10], 12'b0};
    if (!pte_w[0] || xwr == 3'd2 || xwr == 3'd6) begin
      close_walk(FsPage, '0);
      return;
    end
    if (xwr == 3'd0) begin
      if (walk_ph == PhL1) issue_read(base + {20'b0, held_va[21:12], 2'b00}, PhL0);
      else close_walk(FsPage, '0);
      return;
    end
    if (walk_ph == PhL1) begin
      if (pte_w[19:10] != 10'd0) begin
        close_walk(FsPage, '0);
        return;
      end
      base = base | {10'b0, held_va[21:12], 12'b0};
    end
    u = pte_w[4];
    x = pte_w[3];
    w = pte_w[2];
    r = pte_w[1] | (mxr_r & x);
    if ((!u && !priv_r) || (u && priv_r && (held_acc == AccFetch || !sum_r))) begin
      close_walk(FsPage, '0);
      return;
    end
    ok = (held_acc == AccFetch && x) || (held_acc == AccLoad && r) ||
         (held_acc == AccStore && w);
    if (!ok) begin
      close_walk(FsPage, '0);
      return;
    end
    wb = pte_w | 32'h40;
    if (held_acc == AccStore) wb = wb | 32'h80;
    push_res(RkWrite, entry_adr, wb, '0, FsOk, 2'd0, 1'b0);
    close_walk(FsOk, base | {20'b0, held_va[11:0]});
  endfunction

  function void check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      n_mismatch++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  // track config transfers, score output transfers, then track input transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        n_cfg++;
        case (cfg_index_i)
          CfgSatp:  satp_r  = cfg_data_i;
          CfgPriv:  priv_r  = cfg_data_i[0];
          CfgSum:   sum_r   = cfg_data_i[0];
          CfgMxr:   mxr_r   = cfg_data_i[0];
          CfgLimit: limit_r = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        seen_res = {result_kind_o, mem_address_o, pte_out_o, phys_addr_o,
                    fault_status_o, fault_access_o, last_result_o};
        if (walk_results_q.size() == 0) begin
          n_mismatch++;
          $display("%0t: result expected none got kind %h addr %h", $time,
                   seen_res.kind, seen_res.addr);
        end else begin
          want_res = walk_results_q.pop_front();
          n_results++;
          check_field("result_kind", 32'(want_res.kind), 32'(seen_res.kind));
          check_field("mem_address", want_res.addr, seen_res.addr);
          check_field("pte_out", want_res.pte, seen_res.pte);
          check_field("phys_addr", want_res.phys, seen_res.phys);
          check_field("fault_status", 32'(want_res.status), 32'(seen_res.status));
          check_field("fault_access", 32'(want_res.acc), 32'(seen_res.acc));
          check_field("last_result", 32'(want_res.last), 32'(seen_res.last));
        end
      end
      if (in_valid_i && in_ready_o) begin
        n_walk_items++;
        predict_walk(item_kind_i, virt_addr_i, access_kind_i, pte_word_i);
      end
    end
  end

  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left != 0 && !no_idle) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = 0;
        if (!no_idle && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  task automatic send_item(input logic kind, input logic [31:0] va, input logic [1:0] acc,
                           input logic [31:0] pte);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    item_kind_i   <= kind;
    virt_addr_i   <= va;
    access_kind_i <= acc;
    pte_word_i    <= pte;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (walk_results_q.size() != 0 || out_valid_o) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_regs(input logic [31:0] satp, input logic priv, input logic sum,
                              input logic mxr, input logic [31:0] limit);
    wait_idle();
    write_reg(CfgSatp, satp);
    write_reg(CfgPriv, ($urandom & 32'hffff_fffe) | 32'(priv));
    write_reg(CfgSum, ($urandom & 32'hffff_fffe) | 32'(sum));
    write_reg(CfgMxr, ($urandom & 32'hffff_fffe) | 32'(mxr));
    write_reg(CfgLimit, limit);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_pte(input bit want_ptr, input bit level1);
    logic [31:0] p;
    int unsigned r;
    p = $urandom;
    r = $urandom_range(0, 99);
    p[0] = 1'b1;
    if (r < 7) begin
      p[0] = 1'b0;
    end else if (r < 12) begin
      p[3:1] = $urandom_range(0, 1) ? 3'd2 : 3'd6;
    end else if (want_ptr) begin
      p[3:1] = 3'd0;
    end else begin
      p[3:1] = leaf_xwr[$urandom_range(0, 4)];
      if (level1 && $urandom_range(0, 9) < 8) p[19:10] = '0;
    end
    return p;
  endfunction

  task automatic walk_once();
    logic [1:0] acc;
    bit         ptr;
    acc = ($urandom_range(0, 99) < 5) ? AccBad : 2'($urandom_range(0, 2));
    send_item(ItemReq, $urandom, acc, $urandom);
    // leave some walks hanging so the next request cuts them off
    if ($urandom_range(0, 99) < 6) return;
    ptr = $urandom_range(0, 99) < 55;
    send_item(ItemPte, $urandom, 2'($urandom), rand_pte(ptr, 1'b1));
    if (ptr && $urandom_range(0, 99) < 92)
      send_item(ItemPte, $urandom, 2'($urandom), rand_pte($urandom_range(0, 99) < 15, 1'b0));
    if ($urandom_range(0, 99) < 5)
      send_item(ItemPte, $urandom, 2'($urandom), $urandom);
  endtask

  task automatic test_passthrough();
    program_regs(32'h0, 1'b0, 1'b0, 1'b0, 32'hffff_ffff);
    send_item(ItemReq, 32'h0000_0000, AccFetch, 32'h0);
    send_item(ItemReq, 32'hffff_ffff, AccStore, 32'hffff_ffff);
    send_item(ItemReq, 32'h1234_5678, AccBad, 32'h0);
    send_item(ItemPte, 32'h0, AccLoad, 32'h0000_000f);
  endtask

  task automatic test_directed_walks();
    program_regs(32'h8000_0001, 1'b1, 1'b1, 1'b1, 32'hffff_ffff);
    send_item(ItemReq, 32'h0040_0abc, AccLoad, 32'h0);
    send_item(ItemPte, 32'h0, AccFetch, 32'h0010_000b);
    send_item(ItemReq, 32'hffc0_1234, AccStore, 32'h0);
    send_item(ItemPte, 32'h0, AccFetch, 32'h0000_0801);
    send_item(ItemPte, 32'h0, AccFetch, 32'h2af3_7817);
    send_item(ItemReq, 32'h0000_1000, AccFetch, 32'h0);
    send_item(ItemReq, 32'h0000_2000, AccLoad, 32'h0);
    send_item(ItemReq, 32'h0000_0000, AccLoad, 32'h0);
    send_item(ItemPte, 32'h0, AccFetch, 32'h0000_0801);
    send_item(ItemPte, 32'h0, AccFetch, 32'h0000_0801);
    send_item(ItemReq, 32'h0080_0000, AccBad, 32'h0);
    send_item(ItemPte, 32'h0, AccFetch, 32'h0000_000f);
    send_item(ItemReq, 32'h00c0_0000, AccFetch, 32'h0);
    send_item(ItemPte, 32'h0, AccFetch, 32'h0000_0019);
    send_item(ItemReq, 32'h0100_0000, AccLoad, 32'h0);
    send_item(ItemPte, 32'h0, AccFetch, 32'h0000_040b);
    send_item(ItemReq, 32'h0140_0000, AccLoad, 32'h0);
    send_item(ItemPte, 32'h0, AccFetch, 32'h0000_0005);
  endtask

  task automatic test_limit_fault();
    program_regs(32'h8000_0001, 1'b0, 1'b0, 1'b0, 32'h0);
    send_item(ItemReq, 32'h0000_0000, AccLoad, 32'h0);
    program_regs(32'h8000_0001, 1'b0, 1'b0, 1'b0, 32'h0000_2000);
    send_item(ItemReq, 32'h0000_0000, AccStore, 32'h0);
    send_item(ItemPte, 32'h0, AccFetch, 32'h0000_0801);
  endtask

  task automatic test_random_walks(input int unsigned target);
    int unsigned stop_at;
    int unsigned phase_end;
    int unsigned phase;
    logic [31:0] satp;
    logic [31:0] limit;
    stop_at = n_walk_items + target;
    phase   = 0;
    while (n_walk_items < stop_at) begin
      case (phase % 5)
        0:       satp = 32'hffff_ffff;
        1:       satp = 32'h8000_0000;
        2:       satp = $urandom & 32'h7fff_ffff;
        default: satp = $urandom | 32'h8000_0000;
      endcase
      case ($urandom_range(0, 3))
        0, 1:    limit = 32'hffff_ffff;
        2:       limit = 32'h8000_0000;
        default: limit = $urandom;
      endcase
      program_regs(satp, 1'($urandom), 1'($urandom), 1'($urandom), limit);
      phase_end = n_walk_items + 130;
      while (n_walk_items < phase_end && n_walk_items < stop_at) walk_once();
      phase++;
    end
  endtask

  task automatic test_back_to_back(input int unsigned target);
    int unsigned stop_at;
    program_regs($urandom | 32'h8000_0000, 1'b1, 1'b1, 1'b0, 32'hffff_ffff);
    no_idle = 1'b1;
    stop_at = n_walk_items + target;
    while (n_walk_items < stop_at) walk_once();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough();
    test_directed_walks();
    test_limit_fault();
    test_random_walks(1550);
    test_back_to_back(150);
    wait_idle();
    $display("Sent %0d walk items and %0d register writes; %0d results scored.",
             n_walk_items, n_cfg, n_results);
    $display("Covered pass-through, both table levels, every fault path and back-to-back flow.");
    if (n_mismatch == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
design/sv32ptw_pkg.sv
design/sv32_page_table_walker_top.sv
bench/sv32_page_table_walker_top_test.sv
